// ----- hw/rtl/elsd_pkg.sv -----
// ----------------------------------------------------------------------------
// elsd_pkg
// Shared types and constants for the edge list sort and dedupe core.
// ----------------------------------------------------------------------------
`default_nettype none

package elsd_pkg;

	localparam int MAX_EDGES  = 1024;
	localparam int INDEX_BITS = 32;

	localparam int IDX_W  = 32;
	localparam int KEY_W  = 2 * IDX_W;
	localparam int CNT_W  = $clog2(MAX_EDGES + 1);
	localparam int ADDR_W = $clog2(MAX_EDGES);
	localparam int GRP    = 32;
	localparam int NGRP   = (MAX_EDGES + GRP - 1) / GRP;

	localparam logic [IDX_W-1:0] IDX_MASK = {IDX_W{1'b1}} >> (IDX_W - INDEX_BITS);

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [CNT_W:0]    cnt_ext_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [IDX_W-1:0]  idx_t;

	// opcodes
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_FETCH = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// status codes
	localparam logic [2:0] ST_STORED = 3'd0;
	localparam logic [2:0] ST_LOOP   = 3'd1;
	localparam logic [2:0] ST_FULL   = 3'd2;
	localparam logic [2:0] ST_ZERO   = 3'd3;
	localparam logic [2:0] ST_EDGE   = 3'd4;
	localparam logic [2:0] ST_END    = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_DROP_LOOPS = 2'd0;
	localparam logic [1:0] CFG_ONE_BASED  = 2'd1;
	localparam logic [1:0] CFG_ADD_REV    = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		idx_t       row_index;
		idx_t       col_index;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		idx_t       out_row;
		idx_t       out_col;
		logic       is_last;
	} res_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic ins_en;
		key_t ins_key;
		key_t probe_a;
		key_t probe_b;
		cnt_t count;
		cnt_t rd_ptr;
	} bcast_t;

	// per-cell contribution to the reduction tree
	typedef struct packed {
		logic hit_a;
		logic hit_b;
		key_t key;
	} cell_out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/edge_list_sort_dedupe_core.sv -----
// ----------------------------------------------------------------------------
// edge_list_sort_dedupe_core
// Keeps graph edges as a sorted set of unique (row, column) keys in a chain
// of cells; loads insert, fetches return edges in ascending order.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  cmd      in   cmd_valid/cmd_stall   opcode, row_index, col_index
//  res      out  res_valid/res_stall   status, out_row, out_col, is_last
//  cfg      in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
//  a stored load runs LOOK, SUM, EVAL, INS1, INS2, DONE, a fetch or a full load LOOK,
//  SUM, EVAL, DONE, clear and rejected items DONE only; LOOK and SUM register the two
//  OR tree levels over the cell compare; INS1 shifts in the edge and INS2 its mirror
//  a result waits in the output register while the next item is taken
//  the done cycle repeats while the previous result is still stalled
//  reset clears count, read pointer and config; cell contents stay undefined
// ----------------------------------------------------------------------------
`default_nettype none

module edge_list_sort_dedupe_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  elsd_pkg::cmd_t    cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output elsd_pkg::res_t    res,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic              cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_SUM,
		S_EVAL,
		S_INS1,
		S_INS2,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [1:0]         op_q;
	elsd_pkg::key_t     key_a_q;
	elsd_pkg::key_t     key_b_q;
	logic               ins_a_q;
	logic               ins_b_q;
	elsd_pkg::cnt_t     count_q;
	elsd_pkg::cnt_t     rd_ptr_q;
	logic               drop_q;
	logic               one_q;
	logic               rev_q;
	elsd_pkg::res_t     pend_q;
	elsd_pkg::res_t     res_q;
	logic               res_valid_q;

	elsd_pkg::idx_t     row_m;
	elsd_pkg::idx_t     col_m;
	elsd_pkg::idx_t     row_o;
	elsd_pkg::idx_t     col_o;
	logic               zero_bad;
	logic               loop_hit;
	logic               need_b;
	logic [1:0]         need;
	logic               full;
	elsd_pkg::res_t     idle_res;

	elsd_pkg::bcast_t    bc;
	elsd_pkg::key_t      cell_key [elsd_pkg::MAX_EDGES];
	logic                cell_lt  [elsd_pkg::MAX_EDGES];
	elsd_pkg::cell_out_t cell_co  [elsd_pkg::MAX_EDGES];
	elsd_pkg::cell_out_t sum;

	// input conditioning
	always_comb begin
		row_m    = cmd.row_index & elsd_pkg::IDX_MASK;
		col_m    = cmd.col_index & elsd_pkg::IDX_MASK;
		zero_bad = one_q && ((row_m == '0) || (col_m == '0));
		loop_hit = drop_q && (row_m == col_m);
		row_o    = one_q ? row_m - elsd_pkg::idx_t'(1) : row_m;
		col_o    = one_q ? col_m - elsd_pkg::idx_t'(1) : col_m;
	end

	// result set at accept time; eval replaces it for fetched edges and full loads
	always_comb begin
		idle_res = '0;
		case (cmd.opcode)
			elsd_pkg::OP_LOAD: begin
				if (zero_bad) begin
					idle_res.status = elsd_pkg::ST_ZERO;
				end else if (loop_hit) begin
					idle_res.status = elsd_pkg::ST_LOOP;
				end
			end
			elsd_pkg::OP_FETCH: begin
				if (rd_ptr_q >= count_q) begin
					idle_res.status = elsd_pkg::ST_END;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		bc.ins_en  = ((state_q == S_INS1) && ins_a_q) || ((state_q == S_INS2) && ins_b_q);
		bc.ins_key = (state_q == S_INS2) ? key_b_q : key_a_q;
		bc.probe_a = key_a_q;
		bc.probe_b = key_b_q;
		bc.count   = count_q;
		bc.rd_ptr  = rd_ptr_q;
	end

	// space check for the keys not yet present
	always_comb begin
		need_b = rev_q && (key_a_q != key_b_q) && !sum.hit_b;
		need   = {1'b0, !sum.hit_a} + {1'b0, need_b};
		full   = ({1'b0, count_q} + elsd_pkg::cnt_ext_t'(need))
			> elsd_pkg::cnt_ext_t'(elsd_pkg::MAX_EDGES);
	end

	for (genvar g = 0; g < elsd_pkg::MAX_EDGES; g++) begin : g_cell
		if (g == 0) begin : g_head
			elsd_cell u_cell (
				.clk      (clk),
				.idx      (elsd_pkg::addr_t'(g)),
				.bc       (bc),
				.prev_key ('0),
				.prev_lt  (1'b1),
				.key      (cell_key[g]),
				.lt       (cell_lt[g]),
				.co       (cell_co[g])
			);
		end else begin : g_body
			elsd_cell u_cell (
				.clk      (clk),
				.idx      (elsd_pkg::addr_t'(g)),
				.bc       (bc),
				.prev_key (cell_key[g-1]),
				.prev_lt  (cell_lt[g-1]),
				.key      (cell_key[g]),
				.lt       (cell_lt[g]),
				.co       (cell_co[g])
			);
		end
	end

	elsd_tree u_tree (
		.clk    (clk),
		.leaves (cell_co),
		.sum    (sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= '0;
			key_a_q     <= '0;
			key_b_q     <= '0;
			ins_a_q     <= 1'b0;
			ins_b_q     <= 1'b0;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			drop_q      <= 1'b0;
			one_q       <= 1'b0;
			rev_q       <= 1'b0;
			pend_q      <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					elsd_pkg::CFG_DROP_LOOPS: drop_q <= cfg_data;
					elsd_pkg::CFG_ONE_BASED:  one_q  <= cfg_data;
					elsd_pkg::CFG_ADD_REV:    rev_q  <= cfg_data;
					default: ;
				endcase
			end
			if (res_valid_q && !res_stall && (state_q != S_DONE)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						op_q    <= cmd.opcode;
						key_a_q <= {row_o, col_o};
						key_b_q <= {col_o, row_o};
						pend_q  <= idle_res;
						case (cmd.opcode)
							elsd_pkg::OP_LOAD: begin
								if (zero_bad || loop_hit) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_LOOK;
								end
							end
							elsd_pkg::OP_FETCH: begin
								if (rd_ptr_q < count_q) begin
									state_q <= S_LOOK;
								end else begin
									state_q <= S_DONE;
								end
							end
							elsd_pkg::OP_CLEAR: begin
								count_q  <= '0;
								rd_ptr_q <= '0;
								state_q  <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_LOOK: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (op_q == elsd_pkg::OP_FETCH) begin
						pend_q <= '{
							status:  elsd_pkg::ST_EDGE,
							out_row: sum.key[elsd_pkg::KEY_W-1 -: elsd_pkg::IDX_W],
							out_col: sum.key[elsd_pkg::IDX_W-1:0],
							is_last: (rd_ptr_q + elsd_pkg::cnt_t'(1)) == count_q
						};
						rd_ptr_q <= rd_ptr_q + elsd_pkg::cnt_t'(1);
						state_q  <= S_DONE;
					end else if (full) begin
						pend_q.status <= elsd_pkg::ST_FULL;
						state_q       <= S_DONE;
					end else begin
						ins_a_q <= !sum.hit_a;
						ins_b_q <= need_b;
						state_q <= S_INS1;
					end
				end
				S_INS1: begin
					if (ins_a_q) begin
						count_q <= count_q + elsd_pkg::cnt_t'(1);
					end
					state_q <= S_INS2;
				end
				S_INS2: begin
					if (ins_b_q) begin
						count_q <= count_q + elsd_pkg::cnt_t'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || !res_stall) begin
						res_q       <= pend_q;
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= elsd_pkg::cnt_t'(elsd_pkg::MAX_EDGES))
		else $error("key count above capacity");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_ptr_q <= count_q)
		else $error("read pointer beyond key count");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
			((count_q == elsd_pkg::cnt_t'($past(count_q) + elsd_pkg::cnt_t'(1)))
			|| (count_q == '0)))
		else $error("key count moved by more than one insert");

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the done state");

endmodule

`default_nettype wire

// ----- hw/rtl/elsd_cell.sv -----
// ----------------------------------------------------------------------------
// elsd_cell
// One slot of the sorted key chain: holds a key, takes the inserted key or shifts
// from its left neighbor on insert and reports probe hits and the fetch-selected key.
// ----------------------------------------------------------------------------
`default_nettype none

module elsd_cell (
	input  logic               clk,
	input  elsd_pkg::addr_t    idx,
	input  elsd_pkg::bcast_t   bc,
	input  elsd_pkg::key_t     prev_key,
	input  logic               prev_lt,
	output elsd_pkg::key_t     key,
	output logic               lt,
	output elsd_pkg::cell_out_t co
);

	elsd_pkg::key_t key_q;
	elsd_pkg::cnt_t pos;
	logic           occ;

	assign pos = elsd_pkg::cnt_t'(idx);
	assign occ = pos < bc.count;
	assign lt  = occ && (key_q < bc.ins_key);
	assign key = key_q;

	always_comb begin
		co.hit_a = occ && (key_q == bc.probe_a);
		co.hit_b = occ && (key_q == bc.probe_b);
		co.key   = (pos == bc.rd_ptr) ? key_q : '0;
	end

	always_ff @(posedge clk) begin
		if (bc.ins_en && !lt) begin
			key_q <= prev_lt ? bc.ins_key : prev_key;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/elsd_tree.sv -----
// ----------------------------------------------------------------------------
// elsd_tree
// Two-level registered OR tree that gathers probe hits and the selected key
// from all cells.
// ----------------------------------------------------------------------------
`default_nettype none

module elsd_tree (
	input  logic                clk,
	input  elsd_pkg::cell_out_t leaves [elsd_pkg::MAX_EDGES],
	output elsd_pkg::cell_out_t sum
);

	elsd_pkg::cell_out_t grp_d  [elsd_pkg::NGRP];
	elsd_pkg::cell_out_t grp_s1 [elsd_pkg::NGRP];
	elsd_pkg::cell_out_t all_d;
	elsd_pkg::cell_out_t all_s2;

	always_comb begin
		for (int g = 0; g < elsd_pkg::NGRP; g++) begin
			grp_d[g] = '0;
			for (int m = 0; m < elsd_pkg::GRP; m++) begin
				if (g * elsd_pkg::GRP + m < elsd_pkg::MAX_EDGES) begin
					grp_d[g] = elsd_pkg::cell_out_t'(grp_d[g]
						| leaves[g * elsd_pkg::GRP + m]);
				end
			end
		end
	end

	always_comb begin
		all_d = '0;
		for (int g = 0; g < elsd_pkg::NGRP; g++) begin
			all_d = elsd_pkg::cell_out_t'(all_d | grp_s1[g]);
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_d;
		all_s2 <= all_d;
	end

	assign sum = all_s2;

endmodule

`default_nettype wire
